>>> design/power_iteration_eigen_macros.svh
// assertion macros for the power iteration block
`ifndef POWER_ITERATION_EIGEN_MACROS_SVH
`define POWER_ITERATION_EIGEN_MACROS_SVH
`ifndef SYNTHESIS
`define PIE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PIE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PIE_ASSERT(lbl, clk, rst_n, prop, msg)
`define PIE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> design/pie_pkg.sv
// shared constants, codes and helpers for the power iteration block
package pie_pkg;
  localparam int MAX_ORDER  = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(MAX_ORDER);
  localparam int ORD_W      = 5;
  localparam int TOL_W      = 31;
  localparam int RND_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int PROD_W     = 2 * DATA_WIDTH;
  localparam int TERM_W     = PROD_W - 16;
  localparam int ACC_W      = TERM_W + IDX_W;
  localparam int DIVD_W     = DATA_WIDTH + 16;

  localparam logic [1:0] CMD_LOAD_MAT = 2'd0;
  localparam logic [1:0] CMD_LOAD_VEC = 2'd1;
  localparam logic [1:0] CMD_RUN      = 2'd2;

  localparam logic [1:0] KIND_EIGVAL = 2'd0;
  localparam logic [1:0] KIND_EIGVEC = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ORDER      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ROUNDS = 2'd2;

  localparam logic [ORD_W-1:0] ORDER_RST = 5'd3;
  localparam logic [TOL_W-1:0] TOL_RST   = 31'd66;
  localparam logic [RND_W-1:0] RND_RST   = 8'd7;

  typedef logic signed [DATA_WIDTH-1:0] val_t;

  function automatic val_t sat_acc(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'({1'b0, {(DATA_WIDTH-1){1'b1}}});
    lo = -hi - ACC_W'(1);
    if (a > hi) sat_acc = val_t'(hi);
    else if (a < lo) sat_acc = val_t'(lo);
    else sat_acc = a[DATA_WIDTH-1:0];
  endfunction
endpackage

>>> design/pie_if.sv
// handshake channel interfaces: input items, result items and configuration writes
interface pie_in_if;
  import pie_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic [IDX_W-1:0]  row;
  logic [IDX_W-1:0]  col;
  val_t              value;
  modport source (output valid, cmd, row, col, value, input ready);
  modport sink   (input valid, cmd, row, col, value, output ready);
endinterface

interface pie_out_if;
  import pie_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [IDX_W-1:0]  index;
  val_t              result_value;
  logic              converged;
  logic              last;
  modport source (output valid, kind, index, result_value, converged, last, input ready);
  modport sink   (input valid, kind, index, result_value, converged, last, output ready);
endinterface

interface pie_cfg_if;
  import pie_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> design/power_iteration_eigen.sv
// power iteration for the dominant eigenvalue, memory based sequencer
// Usage: in_ch takes load items (matrix entry, start vector entry) and run
// items. A load is written in the cycle it is accepted and gives no result,
// so loads stream at one per cycle while the block is idle. A run gives the
// eigenvalue item and then n eigenvector items on out_ch, the last flagged,
// or a single error item if a round's largest component is zero.
// A round does multiply-accumulate (one matrix memory read, one
// multiply, one accumulate per term), then normalization and the
// estimate check (a 48-step serial divider per component); a run is
// one to max_rounds+1 rounds followed by the output items.
// in_ch is not ready while a run is in progress. cfg_ch is always ready;
// the user must write it only while the block is idle, since the block
// itself does not enforce this.
// A single output register holds the result; when out_ch stalls the
// sequencer waits on it, and a new item is accepted while the final result
// still waits. Reset (rst_n low, synchronous) restores order 3, tolerance
// 66 and max_rounds 7 and drops any pending result; store contents are
// undefined until loaded, and no clearing pass is needed.
module power_iteration_eigen (
  input  logic      clk,
  input  logic      rst_n,
  pie_in_if.sink    in_ch,
  pie_out_if.source out_ch,
  pie_cfg_if.sink   cfg_ch
);
  import pie_pkg::*;
`include "power_iteration_eigen_macros.svh"

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_MUL  = 4'd2;
  localparam logic [3:0] S_ACC  = 4'd3;
  localparam logic [3:0] S_ROW  = 4'd4;
  localparam logic [3:0] S_NRD  = 4'd5;
  localparam logic [3:0] S_NLD  = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_NWR  = 4'd8;
  localparam logic [3:0] S_EVAL = 4'd9;
  localparam logic [3:0] S_OEV  = 4'd10;
  localparam logic [3:0] S_ORD  = 4'd11;
  localparam logic [3:0] S_OWT  = 4'd12;
  localparam logic [3:0] S_OERR = 4'd13;

  localparam int DCNT_W = $clog2(DIVD_W + 1);

  logic [3:0]          state_r, state_nxt;
  logic [ORD_W-1:0]    order_r;
  logic [TOL_W-1:0]    tol_r;
  logic [RND_W-1:0]    max_rnd_r;
  logic [IDX_W-1:0]    nm1_r, i_r, k_r;
  logic [RND_W-1:0]    rnd_r;
  logic                first_r, conv_r;
  val_t                prev_r, big_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [DATA_WIDTH:0] rem_r;
  logic [DIVD_W-1:0]   dq_r;
  logic [DATA_WIDTH-1:0] dvs_r;
  logic [DCNT_W-1:0]   dcnt_r;
  logic                neg_r;

  val_t mat_mem [MAX_ORDER*MAX_ORDER];
  val_t vec_mem [MAX_ORDER];
  val_t prd_mem [MAX_ORDER];
  val_t mat_rdata_r, vec_rdata_r, prd_rdata_r;

  logic                out_valid_r, out_conv_r, out_last_r;
  logic [1:0]          out_kind_r;
  logic [IDX_W-1:0]    out_index_r;
  val_t                out_value_r;

  logic in_xfer, out_free, out_load, vec_we;
  logic [1:0] ld_kind;
  logic [IDX_W-1:0] ld_index;
  val_t ld_value;
  logic ld_last;
  val_t vec_wdata, row_sat, div_res;
  logic [IDX_W-1:0] vec_waddr;
  logic [DATA_WIDTH:0] rem_sh, rem_sub;
  logic div_ge;
  logic [ORD_W-1:0] n_clamp;
  logic [DATA_WIDTH:0] diff, diff_abs;
  logic [RND_W-1:0] rnd_inc;
  logic [DATA_WIDTH-1:0] abs_p, abs_big;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = out_kind_r;
  assign out_ch.index        = out_index_r;
  assign out_ch.result_value = out_value_r;
  assign out_ch.converged    = out_conv_r;
  assign out_ch.last         = out_last_r;

  assign row_sat  = sat_acc(acc_r);
  assign rem_sh   = {rem_r[DATA_WIDTH-1:0], dq_r[DIVD_W-1]};
  assign rem_sub  = rem_sh - {1'b0, dvs_r};
  assign div_ge   = (rem_sh >= {1'b0, dvs_r});
  assign diff     = {big_r[DATA_WIDTH-1], big_r} - {prev_r[DATA_WIDTH-1], prev_r};
  assign diff_abs = diff[DATA_WIDTH] ? -diff : diff;
  assign rnd_inc  = rnd_r + RND_W'(1);
  assign abs_p    = prd_rdata_r[DATA_WIDTH-1] ? -prd_rdata_r : prd_rdata_r;
  assign abs_big  = big_r[DATA_WIDTH-1] ? -big_r : big_r;

  always_comb begin
    if (order_r == '0) n_clamp = ORD_W'(1);
    else if (order_r > ORD_W'(MAX_ORDER)) n_clamp = ORD_W'(MAX_ORDER);
    else n_clamp = order_r;
  end

  always_comb begin
    if (neg_r) begin
      if (dq_r > DIVD_W'({1'b1, {(DATA_WIDTH-1){1'b0}}}))
        div_res = {1'b1, {(DATA_WIDTH-1){1'b0}}};
      else
        div_res = -dq_r[DATA_WIDTH-1:0];
    end else begin
      if (dq_r >= DIVD_W'({1'b1, {(DATA_WIDTH-1){1'b0}}}))
        div_res = {1'b0, {(DATA_WIDTH-1){1'b1}}};
      else
        div_res = dq_r[DATA_WIDTH-1:0];
    end
  end

  // vector memory write source
  always_comb begin
    vec_we    = 1'b0;
    vec_waddr = i_r;
    vec_wdata = prd_rdata_r;
    if (in_xfer && in_ch.cmd == CMD_LOAD_VEC) begin
      vec_we    = 1'b1;
      vec_waddr = in_ch.row;
      vec_wdata = in_ch.value;
    end else if (state_r == S_NLD && big_r == '0) begin
      vec_we = 1'b1;
    end else if (state_r == S_NWR) begin
      vec_we    = 1'b1;
      vec_wdata = div_res;
    end
  end

  // output register load
  always_comb begin
    out_load = 1'b0;
    ld_kind  = KIND_EIGVAL;
    ld_index = '0;
    ld_value = prev_r;
    ld_last  = 1'b0;
    unique case (state_r)
      S_OEV: out_load = out_free;
      S_OWT: begin
        out_load = out_free;
        ld_kind  = KIND_EIGVEC;
        ld_index = k_r;
        ld_value = vec_rdata_r;
        ld_last  = (k_r == nm1_r);
      end
      S_OERR: begin
        out_load = out_free;
        ld_kind  = KIND_ERROR;
        ld_value = '0;
        ld_last  = 1'b1;
      end
      default: out_load = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_xfer && in_ch.cmd == CMD_RUN) state_nxt = S_RD;
      S_RD:   state_nxt = S_MUL;
      S_MUL:  state_nxt = S_ACC;
      S_ACC:  state_nxt = (k_r == nm1_r) ? S_ROW : S_RD;
      S_ROW:  state_nxt = (i_r == nm1_r) ? S_NRD : S_RD;
      S_NRD:  state_nxt = S_NLD;
      S_NLD: begin
        if (big_r != '0) state_nxt = S_DIV;
        else if (i_r == nm1_r) state_nxt = S_EVAL;
        else state_nxt = S_NRD;
      end
      S_DIV:  if (dcnt_r == DCNT_W'(DIVD_W - 1)) state_nxt = S_NWR;
      S_NWR:  state_nxt = (i_r == nm1_r) ? S_EVAL : S_NRD;
      S_EVAL: begin
        priority if (big_r == '0) state_nxt = S_OERR;
        else if (first_r) state_nxt = (max_rnd_r == '0) ? S_OEV : S_RD;
        else if (diff_abs < (DATA_WIDTH+1)'(tol_r)) state_nxt = S_OEV;
        else if (rnd_inc < max_rnd_r) state_nxt = S_RD;
        else state_nxt = S_OEV;
      end
      S_OEV:  if (out_free) state_nxt = S_ORD;
      S_ORD:  state_nxt = S_OWT;
      S_OWT:  if (out_free) state_nxt = (k_r == nm1_r) ? S_IDLE : S_ORD;
      S_OERR: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (in_xfer && in_ch.cmd == CMD_LOAD_MAT) mat_mem[{in_ch.row, in_ch.col}] <= in_ch.value;
    mat_rdata_r <= mat_mem[{i_r, k_r}];
  end

  always_ff @(posedge clk) begin
    if (vec_we) vec_mem[vec_waddr] <= vec_wdata;
    vec_rdata_r <= vec_mem[k_r];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_ROW) prd_mem[i_r] <= row_sat;
    prd_rdata_r <= prd_mem[i_r];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      order_r     <= ORDER_RST;
      tol_r       <= TOL_RST;
      max_rnd_r   <= RND_RST;
      out_valid_r <= 1'b0;
      nm1_r       <= '0;
      i_r         <= '0;
      k_r         <= '0;
      rnd_r       <= '0;
      first_r     <= 1'b0;
      conv_r      <= 1'b0;
      dcnt_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          REG_ORDER:      order_r   <= cfg_ch.data[ORD_W-1:0];
          REG_TOLERANCE:  tol_r     <= cfg_ch.data[TOL_W-1:0];
          REG_MAX_ROUNDS: max_rnd_r <= cfg_ch.data[RND_W-1:0];
          default: ;
        endcase
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: if (in_xfer && in_ch.cmd == CMD_RUN) begin
          nm1_r   <= IDX_W'(n_clamp - ORD_W'(1));
          i_r     <= '0;
          k_r     <= '0;
          rnd_r   <= '0;
          first_r <= 1'b1;
          conv_r  <= 1'b0;
        end
        S_ACC: if (k_r != nm1_r) k_r <= k_r + IDX_W'(1);
        S_ROW: begin
          k_r <= '0;
          i_r <= (i_r == nm1_r) ? '0 : i_r + IDX_W'(1);
        end
        S_NLD: begin
          dcnt_r <= '0;
          if (big_r == '0) i_r <= (i_r == nm1_r) ? '0 : i_r + IDX_W'(1);
        end
        S_DIV: dcnt_r <= dcnt_r + DCNT_W'(1);
        S_NWR: i_r <= (i_r == nm1_r) ? '0 : i_r + IDX_W'(1);
        S_EVAL: begin
          i_r <= '0;
          k_r <= '0;
          if (first_r) first_r <= 1'b0;
          else begin
            rnd_r <= rnd_inc;
            if (diff_abs < (DATA_WIDTH+1)'(tol_r)) conv_r <= 1'b1;
          end
        end
        S_OWT: if (out_free) k_r <= k_r + IDX_W'(1);
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: acc_r <= '0;
      S_MUL:  prod_r <= mat_rdata_r * vec_rdata_r;
      S_ACC:  acc_r <= acc_r + ACC_W'(prod_r >>> 16);
      S_ROW: begin
        acc_r <= '0;
        if (i_r == '0 || row_sat > big_r) big_r <= row_sat;
      end
      S_NLD: begin
        rem_r <= '0;
        dq_r  <= {abs_p, 16'b0};
        dvs_r <= abs_big;
        neg_r <= prd_rdata_r[DATA_WIDTH-1] ^ big_r[DATA_WIDTH-1];
      end
      S_DIV: begin
        rem_r <= div_ge ? rem_sub : rem_sh;
        dq_r  <= {dq_r[DIVD_W-2:0], div_ge};
      end
      S_EVAL: if (big_r != '0) prev_r <= big_r;
      default: ;
    endcase
    if (out_load) begin
      out_kind_r  <= ld_kind;
      out_index_r <= ld_index;
      out_value_r <= ld_value;
      out_conv_r  <= (ld_kind == KIND_ERROR) ? 1'b0 : conv_r;
      out_last_r  <= ld_last;
    end
  end

  `PIE_ASSERT(a_idle_no_new_result, clk, rst_n,
    (state_r == S_IDLE && !out_valid_r) |=> !out_valid_r,
    "result appeared while idle")
  `PIE_ASSERT(a_div_nonzero, clk, rst_n,
    (state_r == S_DIV) |-> (dvs_r != '0),
    "division by zero in normalization")
  `PIE_ASSERT(a_idx_in_range, clk, rst_n,
    (state_r != S_IDLE) |-> (i_r <= nm1_r && k_r <= nm1_r),
    "index beyond order")
  `PIE_ASSERT(a_last_not_eigval, clk, rst_n,
    (out_valid_r && out_last_r) |-> (out_kind_r != KIND_EIGVAL),
    "last flag on eigenvalue item")
endmodule

>>> dv/pie_tb_pkg.sv
// stimulus row type and helpers shared by the power iteration testbench
`timescale 1ns / 1ps
package pie_tb_pkg;
  import pie_pkg::*;

  typedef struct packed {
    logic [1:0]       kind;
    logic [IDX_W-1:0] index;
    val_t             result_value;
    logic             converged;
    logic             last;
  } eig_res_t;

  typedef struct {
    logic [1:0]       cmd;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    val_t             value;
    bit               typed;
    eig_res_t         typed_res;
  } stim_row_t;
endpackage

>>> dv/tb_power_iteration_eigen.sv
// self-checking testbench for the power iteration eigenvalue block
`timescale 1ns / 1ps
module tb_power_iteration_eigen;
  import pie_pkg::*;
  import pie_tb_pkg::*;

  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;
  localparam int RAND_ITEMS = 80;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  pie_in_if  in_ch ();
  pie_out_if out_ch ();
  pie_cfg_if cfg_ch ();

  power_iteration_eigen dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg_ch(cfg_ch.sink)
  );

  // predictor state
  longint mat [MAX_ORDER*MAX_ORDER];
  longint vec [MAX_ORDER];
  bit     mat_wr [MAX_ORDER*MAX_ORDER];
  bit     vec_wr [MAX_ORDER];
  int unsigned cur_order = ORDER_RST;
  longint      cur_tol = TOL_RST;
  int unsigned cur_rounds = RND_RST;

  eig_res_t expected_q [$];
  int errors = 0;
  int got_results = 0;
  bit quiet = 1'b0;
  bit long_hold = 1'b0;
  bit sink_go = 1'b0;

  task automatic report(input string what, input eig_res_t got, input eig_res_t want);
    errors++;
    $display("mismatch %s: got k%0d i%0d v%0d c%0d l%0d want k%0d i%0d v%0d c%0d l%0d", what,
             got.kind, got.index, got.result_value, got.converged, got.last,
             want.kind, want.index, want.result_value, want.converged, want.last);
  endtask

  function automatic longint clamp32(input longint x);
    if (x > VMAX) return VMAX;
    if (x < VMIN) return VMIN;
    return x;
  endfunction

  // one multiply, normalise round; returns 0 on zero divisor
  function automatic bit eigen_round(input int n, output longint big);
    longint prod [MAX_ORDER];
    longint acc;
    for (int i = 0; i < n; i++) begin
      acc = 0;
      for (int k = 0; k < n; k++) acc += (mat[i*MAX_ORDER+k] * vec[k]) >>> 16;
      prod[i] = clamp32(acc);
    end
    big = prod[0];
    for (int i = 1; i < n; i++) if (prod[i] > big) big = prod[i];
    for (int i = 0; i < n; i++) vec[i] = prod[i];
    if (big == 0) return 1'b0;
    for (int i = 0; i < n; i++) vec[i] = clamp32((prod[i] * 65536) / big);
    return 1'b1;
  endfunction

  function automatic void predict_item(input logic [1:0] cmd, input int r, input int c,
                                       input val_t v);
    int n;
    longint est, prev, diff;
    int rnd;
    bit conv;
    eig_res_t e;
    if (cmd == CMD_LOAD_MAT) begin
      mat[r*MAX_ORDER+c] = v;
      mat_wr[r*MAX_ORDER+c] = 1'b1;
      return;
    end
    if (cmd == CMD_LOAD_VEC) begin
      vec[r] = v;
      vec_wr[r] = 1'b1;
      return;
    end
    if (cmd != CMD_RUN) return;
    n = cur_order < 1 ? 1 : (cur_order > MAX_ORDER ? MAX_ORDER : cur_order);
    conv = 1'b0;
    e = '0;
    e.kind = KIND_ERROR;
    e.last = 1'b1;
    if (!eigen_round(n, est)) begin
      expected_q.push_back(e);
      return;
    end
    prev = est;
    rnd = 0;
    while (rnd < cur_rounds) begin
      if (!eigen_round(n, est)) begin
        expected_q.push_back(e);
        return;
      end
      rnd++;
      diff = est - prev;
      if (diff < 0) diff = -diff;
      prev = est;
      if (diff < cur_tol) begin
        conv = 1'b1;
        break;
      end
    end
    e = '{KIND_EIGVAL, '0, val_t'(prev), conv, 1'b0};
    expected_q.push_back(e);
    for (int i = 0; i < n; i++) begin
      e = '{KIND_EIGVEC, IDX_W'(i), val_t'(vec[i]), conv, i == n - 1};
      expected_q.push_back(e);
    end
  endfunction

  function automatic bit run_is_safe();
    int n;
    n = cur_order < 1 ? 1 : (cur_order > MAX_ORDER ? MAX_ORDER : cur_order);
    for (int i = 0; i < n; i++) begin
      if (!vec_wr[i]) return 1'b0;
      for (int k = 0; k < n; k++) if (!mat_wr[i*MAX_ORDER+k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic send_item(input logic [1:0] cmd, input int r, input int c, input val_t v);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 6);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.row <= IDX_W'(r);
    in_ch.col <= IDX_W'(c);
    in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
    predict_item(cmd, r, c, v);
  endtask

  task automatic idle_in();
    in_ch.valid <= 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= d;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_ORDER) cur_order = d[4:0];
    else if (idx == REG_TOLERANCE) cur_tol = d[30:0];
    else if (idx == REG_MAX_ROUNDS) cur_rounds = d[7:0];
  endtask

  task automatic drain();
    idle_in();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic load_matrix(input int n, input bit diag_heavy);
    val_t v;
    for (int i = 0; i < n; i++)
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 15) == 0) v = $urandom();
        else v = $signed($urandom_range(0, 4 * 65536)) - 2 * 65536;
        if (diag_heavy && i == k) v = (n + 2) * 65536 + $urandom_range(0, 65535);
        send_item(CMD_LOAD_MAT, i, k, v);
      end
    for (int i = 0; i < n; i++) send_item(CMD_LOAD_VEC, i, 0,
                                          $signed($urandom_range(1, 2 * 65536)));
  endtask

  // result checker with random stall
  always @(posedge clk) begin
    eig_res_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.kind, out_ch.index, out_ch.result_value, out_ch.converged, out_ch.last};
      got_results++;
      if (expected_q.size() == 0) begin
        report("unexpected transfer", got, '0);
      end else begin
        want = expected_q.pop_front();
        if (got.kind != want.kind) report("kind", got, want);
        else if (got.index != want.index) report("index", got, want);
        else if (got.result_value != want.result_value) report("value", got, want);
        else if (got.converged != want.converged) report("converged", got, want);
        else if (got.last != want.last) report("last", got, want);
      end
    end
  end

  initial begin
    int burst;
    out_ch.ready = 1'b0;
    wait (sink_go);
    forever begin
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (10000) @(posedge clk);
        long_hold = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 6);
        out_ch.ready <= 1'b0;
        repeat (burst) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    #500ms;
    $display("TEST FAILED");
    $finish;
  end

  stim_row_t dir_rows [$];

  initial begin
    stim_row_t s;
    int n, k;
    logic [1:0] c;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_LOAD_MAT;
    in_ch.row = '0;
    in_ch.col = '0;
    in_ch.value = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_ORDER;
    cfg_ch.data = '0;
    foreach (mat[i]) begin
      mat[i] = 0;
      mat_wr[i] = 1'b0;
    end
    foreach (vec[i]) begin
      vec[i] = 0;
      vec_wr[i] = 1'b0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    sink_go = 1'b1;

    // directed: reset order 3, zero matrix gives error, identity gives 1.0
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) dir_rows.push_back('{CMD_LOAD_MAT, i, j, 0, 0, '0});
    for (int i = 0; i < 3; i++) dir_rows.push_back('{CMD_LOAD_VEC, i, 0, 65536, 0, '0});
    dir_rows.push_back('{CMD_RUN, 0, 0, 0, 1, '{KIND_ERROR, 0, 0, 0, 1}});
    dir_rows.push_back('{2'd3, 15, 15, 32'sh7fffffff, 0, '0});
    dir_rows.push_back('{CMD_LOAD_MAT, 15, 15, 32'sh80000000, 0, '0});
    dir_rows.push_back('{CMD_LOAD_VEC, 15, 0, 32'sh7fffffff, 0, '0});
    for (int i = 0; i < 3; i++) dir_rows.push_back('{CMD_LOAD_MAT, i, i, 65536, 0, '0});
    for (int i = 0; i < 3; i++) dir_rows.push_back('{CMD_LOAD_VEC, i, 0, 65536, 0, '0});
    dir_rows.push_back('{CMD_RUN, 0, 0, 0, 0, '0});
    foreach (dir_rows[i]) begin
      s = dir_rows[i];
      if (s.typed) begin
        send_item(s.cmd, s.row, s.col, s.value);
        void'(expected_q.pop_back());
        expected_q.push_back(s.typed_res);
      end else send_item(s.cmd, s.row, s.col, s.value);
    end
    drain();

    // extremes of configuration
    write_reg(REG_ORDER, 5'd1);
    write_reg(REG_MAX_ROUNDS, 8'd0);
    write_reg(REG_TOLERANCE, 32'h7fffffff);
    send_item(CMD_LOAD_MAT, 0, 0, 32'sh7fffffff);
    send_item(CMD_LOAD_VEC, 0, 0, 32'sh7fffffff);
    send_item(CMD_RUN, 0, 0, 0);
    send_item(CMD_LOAD_MAT, 0, 0, 32'sh80000000);
    send_item(CMD_LOAD_VEC, 0, 0, -65536);
    send_item(CMD_RUN, 0, 0, 32'shffffffff);
    drain();
    write_reg(REG_ORDER, 5'd0);
    write_reg(REG_MAX_ROUNDS, 8'd255);
    write_reg(REG_TOLERANCE, 32'd0);
    send_item(CMD_RUN, 0, 0, 0);
    drain();
    write_reg(REG_ORDER, 5'd31);
    write_reg(REG_MAX_ROUNDS, 8'd3);
    write_reg(REG_TOLERANCE, 32'd66);
    load_matrix(MAX_ORDER, 1'b1);
    send_item(CMD_RUN, 0, 0, 0);
    // long stall while further loads and a run queue up
    long_hold = 1'b1;
    send_item(CMD_LOAD_VEC, 3, 0, 65536);
    send_item(CMD_RUN, 0, 0, 0);
    send_item(CMD_LOAD_MAT, 0, 1, 65536);
    drain();

    // random phases, mostly small orders
    k = 0;
    while (k < RAND_ITEMS) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
      write_reg(REG_ORDER, n);
      write_reg(REG_MAX_ROUNDS, $urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                                          : $urandom_range(1, 12));
      write_reg(REG_TOLERANCE, $urandom_range(0, 2) == 0 ? $urandom() : $urandom_range(0, 4000));
      if (k > RAND_ITEMS - 25) quiet = 1'b1;
      load_matrix(n, $urandom_range(0, 1));
      k += n * n + n;
      repeat ($urandom_range(1, 3)) begin
        c = $urandom_range(0, 3);
        if (c == CMD_LOAD_MAT || c == CMD_LOAD_VEC)
          send_item(c, $urandom_range(0, 15), $urandom_range(0, 15), $urandom());
        else if (c == 2'd3) send_item(c, $urandom(), $urandom(), $urandom());
        if (run_is_safe()) send_item(CMD_RUN, $urandom(), $urandom(), $urandom());
        k++;
      end
      drain();
    end

    if (errors == 0 && expected_q.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

>>> sim.f
+incdir+design
design/pie_pkg.sv
design/pie_if.sv
design/power_iteration_eigen.sv
dv/pie_tb_pkg.sv
dv/tb_power_iteration_eigen.sv
